[rtl/core/dpbc_pkg.sv]
// Shared types and constants for the disk partition bounds check pipeline.
`timescale 1ns / 1ps

package dpbc_pkg;

   // Sector size as a power of two.
   localparam int SECTOR_SHIFT = 9;

   // Field widths.
   localparam int BLK_W = 32;
   localparam int CNT_W = 31;
   localparam int SPC_W = 24;
   localparam int SEC_W = CNT_W + 1 - SECTOR_SHIFT;

   // One quotient bit per divider stage.
   localparam int DIV_STAGES = BLK_W;

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_SPC = 1'b0;
   localparam logic CSR_IDX_LABEL = 1'b1;

   // Status codes.
   localparam logic [1:0] STATUS_PROCEED = 2'd0;
   localparam logic [1:0] STATUS_END = 2'd1;
   localparam logic [1:0] STATUS_LABEL_RO = 2'd2;
   localparam logic [1:0] STATUS_INVALID = 2'd3;

   // Transaction state carried through the divider stages.
   typedef struct packed {
      logic [1:0] status;
      logic [CNT_W-1:0] new_byte_count;
      logic [CNT_W-1:0] residual_count;
      logic cyl_ok;
      logic [SPC_W-1:0] rem;
      logic [BLK_W-1:0] num;
   } item_type;

   // Finished result.
   typedef struct packed {
      logic [1:0] status;
      logic [CNT_W-1:0] new_byte_count;
      logic [CNT_W-1:0] residual_count;
      logic [CNT_W-1:0] cylinder;
   } result_type;

endpackage

[rtl/core/dpbc_front.sv]
// Decode stage: label protection, range checks, truncation and dividend setup.
`timescale 1ns / 1ps

module dpbc_front (
   input  logic [dpbc_pkg::BLK_W-1:0] block_number,
   input  logic [dpbc_pkg::CNT_W-1:0] byte_count,
   input  logic is_read,
   input  logic write_label_allowed,
   input  logic [dpbc_pkg::CNT_W-1:0] part_offset,
   input  logic [dpbc_pkg::CNT_W-1:0] part_size,
   input  logic [dpbc_pkg::CNT_W-1:0] label_offset,
   output dpbc_pkg::item_type item
);

   logic signed [dpbc_pkg::BLK_W:0] abs_sector;
   logic signed [dpbc_pkg::BLK_W:0] blk_ext;
   logic signed [dpbc_pkg::BLK_W:0] size_ext;
   logic signed [dpbc_pkg::BLK_W:0] room;
   logic [dpbc_pkg::CNT_W:0] count_round;
   logic [dpbc_pkg::SEC_W-1:0] secs;
   logic [dpbc_pkg::BLK_W:0] end_sector;
   logic label_hit;
   logic crosses;

   // Absolute start sector and remaining room in the partition
   always_comb begin
      blk_ext = $signed({block_number[dpbc_pkg::BLK_W-1], block_number});
      size_ext = $signed({2'b00, part_size});
      abs_sector = blk_ext + $signed({2'b00, part_offset});
      room = size_ext - blk_ext;
      label_hit = !is_read && !write_label_allowed &&
                  (abs_sector <= $signed({2'b00, label_offset}));
   end

   // Round the byte count up to whole sectors
   always_comb begin
      count_round = {1'b0, byte_count} +
                    (dpbc_pkg::CNT_W + 1)'((1 << dpbc_pkg::SECTOR_SHIFT) - 1);
      secs = count_round[dpbc_pkg::CNT_W:dpbc_pkg::SECTOR_SHIFT];
      end_sector = {1'b0, block_number} + (dpbc_pkg::BLK_W + 1)'(secs);
      crosses = end_sector > (dpbc_pkg::BLK_W + 1)'(part_size);
   end

   // Pick the status and the adjusted counts
   always_comb begin
      item.status = dpbc_pkg::STATUS_PROCEED;
      item.new_byte_count = byte_count;
      item.residual_count = '0;
      item.cyl_ok = 1'b0;
      item.rem = '0;
      item.num = abs_sector[dpbc_pkg::BLK_W-1:0];
      if (label_hit) begin
         item.status = dpbc_pkg::STATUS_LABEL_RO;
      end else if (block_number[dpbc_pkg::BLK_W-1]) begin
         item.status = dpbc_pkg::STATUS_INVALID;
      end else if (crosses && (room == '0)) begin
         item.status = dpbc_pkg::STATUS_END;
         item.residual_count = byte_count;
      end else if (crosses && (room[dpbc_pkg::BLK_W] || room == '0)) begin
         item.status = dpbc_pkg::STATUS_INVALID;
      end else if (crosses) begin
         item.new_byte_count = {room[dpbc_pkg::CNT_W-1-dpbc_pkg::SECTOR_SHIFT:0],
                                {dpbc_pkg::SECTOR_SHIFT{1'b0}}};
         item.cyl_ok = 1'b1;
      end else begin
         item.cyl_ok = 1'b1;
      end
   end

endmodule

[rtl/core/dpbc_div_step.sv]
// One restoring division step: produces one quotient bit of the cylinder.
`timescale 1ns / 1ps

module dpbc_div_step (
   input  dpbc_pkg::item_type item_in,
   input  logic [dpbc_pkg::SPC_W-1:0] divisor,
   output dpbc_pkg::item_type item_out
);

   logic [dpbc_pkg::SPC_W:0] trial;
   logic [dpbc_pkg::SPC_W:0] diff;
   logic q_bit;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      trial = {item_in.rem, item_in.num[dpbc_pkg::BLK_W-1]};
      diff = trial - {1'b0, divisor};
      q_bit = trial >= {1'b0, divisor};
      item_out = item_in;
      item_out.rem = q_bit ? diff[dpbc_pkg::SPC_W-1:0] : trial[dpbc_pkg::SPC_W-1:0];
      item_out.num = {item_in.num[dpbc_pkg::BLK_W-2:0], q_bit};
   end

endmodule

[rtl/core/disk_partition_bounds_check.sv]
// Top level of the disk partition bounds check: registers, pipeline and output skid.
//
// Each request transaction on the req_ channel carries a block number relative to
// its partition, a byte count, the read flag, the label write permission and the
// partition offset and size. The block returns one rsp_ transaction per request,
// in order: a status, the possibly truncated byte count, the residual count and
// the cylinder of the absolute start sector.
// The csr_ port holds sectors per cylinder (address 0) and the absolute offset
// of the label partition (address 4); write them only while no request is in
// flight.
// The accepting edge loads the decode stage, 32 divider stages each resolve one
// quotient bit of the cylinder, and the output register follows. One request is
// accepted every cycle while the skid register is empty.
// When the receiver stalls, the output register holds its result and a skid
// register catches the next one; while the skid register is full the whole
// pipeline freezes and req_ready is low. Nothing is dropped or repeated.
// Reset clears all valid bits and loads sectors per cylinder with 1 and the
// label offset with 0.
`timescale 1ns / 1ps

module disk_partition_bounds_check (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [dpbc_pkg::BLK_W-1:0] req_block_number,
   input  logic [dpbc_pkg::CNT_W-1:0] req_byte_count,
   input  logic req_is_read,
   input  logic req_write_label_allowed,
   input  logic [dpbc_pkg::CNT_W-1:0] req_part_offset,
   input  logic [dpbc_pkg::CNT_W-1:0] req_part_size,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic [dpbc_pkg::CNT_W-1:0] rsp_new_byte_count,
   output logic [dpbc_pkg::CNT_W-1:0] rsp_residual_count,
   output logic [dpbc_pkg::CNT_W-1:0] rsp_cylinder,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [dpbc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dpbc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dpbc_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   logic [dpbc_pkg::SPC_W-1:0] spc_ff;
   logic [dpbc_pkg::CNT_W-1:0] label_ff;
   logic [dpbc_pkg::SPC_W-1:0] divisor;
   logic csr_write;

   dpbc_pkg::item_type front_item;
   dpbc_pkg::item_type stage_ff [0:dpbc_pkg::DIV_STAGES];
   dpbc_pkg::item_type step_out [0:dpbc_pkg::DIV_STAGES-1];
   logic [dpbc_pkg::DIV_STAGES:0] valid_ff;
   logic advance;

   dpbc_pkg::result_type final_res;
   dpbc_pkg::result_type out_ff;
   dpbc_pkg::result_type out_in;
   dpbc_pkg::result_type skid_ff;
   dpbc_pkg::result_type skid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic skid_valid_ff;
   logic skid_valid_in;
   logic final_valid;

   // Register file
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff <= dpbc_pkg::SPC_W'(1);
         label_ff <= '0;
      end else if (csr_write) begin
         case (paddr[2])
            dpbc_pkg::CSR_IDX_SPC: spc_ff <= pwdata[dpbc_pkg::SPC_W-1:0];
            dpbc_pkg::CSR_IDX_LABEL: label_ff <= pwdata[dpbc_pkg::CNT_W-1:0];
            default: spc_ff <= spc_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         dpbc_pkg::CSR_IDX_SPC: prdata = dpbc_pkg::CSR_DATA_W'(spc_ff);
         dpbc_pkg::CSR_IDX_LABEL: prdata = dpbc_pkg::CSR_DATA_W'(label_ff);
         default: prdata = '0;
      endcase
   end

   // Treat a zero divisor as one
   assign divisor = (spc_ff == '0) ? dpbc_pkg::SPC_W'(1) : spc_ff;

   // Decode stage
   dpbc_front u_front (
      .block_number(req_block_number),
      .byte_count(req_byte_count),
      .is_read(req_is_read),
      .write_label_allowed(req_write_label_allowed),
      .part_offset(req_part_offset),
      .part_size(req_part_size),
      .label_offset(label_ff),
      .item(front_item)
   );

   // Divider stages
   for (genvar k = 0; k < dpbc_pkg::DIV_STAGES; k++) begin : g_div
      dpbc_div_step u_step (
         .item_in(stage_ff[k]),
         .divisor(divisor),
         .item_out(step_out[k])
      );
   end

   // Advance the pipeline whenever the skid register is empty
   assign advance = !skid_valid_ff;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[dpbc_pkg::DIV_STAGES-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= front_item;
         for (int k = 1; k <= dpbc_pkg::DIV_STAGES; k++) begin
            stage_ff[k] <= step_out[k-1];
         end
      end
   end

   // Saturate the cylinder and zero it unless the transfer proceeds
   always_comb begin
      final_res.status = stage_ff[dpbc_pkg::DIV_STAGES].status;
      final_res.new_byte_count = stage_ff[dpbc_pkg::DIV_STAGES].new_byte_count;
      final_res.residual_count = stage_ff[dpbc_pkg::DIV_STAGES].residual_count;
      if (!stage_ff[dpbc_pkg::DIV_STAGES].cyl_ok) begin
         final_res.cylinder = '0;
      end else if (stage_ff[dpbc_pkg::DIV_STAGES].num[dpbc_pkg::BLK_W-1]) begin
         final_res.cylinder = '1;
      end else begin
         final_res.cylinder = stage_ff[dpbc_pkg::DIV_STAGES].num[dpbc_pkg::CNT_W-1:0];
      end
      final_valid = valid_ff[dpbc_pkg::DIV_STAGES] && advance;
   end

   // Output register with skid stage
   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_in = final_res;
         out_valid_in = final_valid;
      end else if (final_valid) begin
         skid_in = final_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_new_byte_count = out_ff.new_byte_count;
   assign rsp_residual_count = out_ff.residual_count;
   assign rsp_cylinder = out_ff.cylinder;

endmodule
